/* rtl/core/sbb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package sbb_pkg;
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int PIX_W         = 32;
  localparam int ERR_W         = 8;
  localparam logic [ERR_W-1:0] ERR_RST = 8'hAA;
  localparam int FIFO_DEPTH    = 8;

  // configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_ALPHA  = 2'd2;

  // one filtered pixel headed for the output channel
  typedef struct packed {
    logic             done;
    logic [PIX_W-1:0] pix;
  } result_t;

  // pushes into the output queue from the horizontal pass
  typedef struct packed {
    logic push0;
    logic push1;
  } push_t;
endpackage
`default_nettype wire

/* rtl/core/sbb_lane.sv */
`timescale 1ns / 1ps
`default_nettype none
// One byte of a [1,2,1] tap with carried 2-bit rounding error.
module sbb_lane (
  input  wire logic [7:0] a,
  input  wire logic [7:0] b,
  input  wire logic [7:0] c,
  input  wire logic [1:0] e_in,
  input  wire logic       bypass,
  output logic      [7:0] v,
  output logic      [1:0] e_out
);
  logic [9:0] sum;

  assign sum = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c} + {8'h00, e_in};

  always_comb begin
    if (bypass) begin
      v     = b;
      e_out = e_in;
    end else begin
      v     = sum[9:2];
      e_out = sum[1:0];
    end
  end
endmodule
`default_nettype wire

/* rtl/core/sbb_pass.sv */
`timescale 1ns / 1ps
`default_nettype none
// Four byte lanes side by side; the merge packs their bytes and errors.
module sbb_pass (
  input  wire logic [sbb_pkg::PIX_W-1:0] a,
  input  wire logic [sbb_pkg::PIX_W-1:0] b,
  input  wire logic [sbb_pkg::PIX_W-1:0] c,
  input  wire logic [sbb_pkg::ERR_W-1:0] err_in,
  input  wire logic                      alpha_en,
  output logic      [sbb_pkg::PIX_W-1:0] pix,
  output logic      [sbb_pkg::ERR_W-1:0] err_out
);
  logic [7:0] lv [4];
  logic [1:0] le [4];

  for (genvar k = 0; k < 4; k++) begin : g_lane
    sbb_lane u_lane (
      .a      (a[8*k +: 8]),
      .b      (b[8*k +: 8]),
      .c      (c[8*k +: 8]),
      .e_in   (err_in[2*k +: 2]),
      .bypass ((k == 0) && !alpha_en),
      .v      (lv[k]),
      .e_out  (le[k])
    );
  end

  // merge lanes
  assign pix     = {lv[3], lv[2], lv[1], lv[0]};
  assign err_out = {le[3], le[2], le[1], le[0]};
endmodule
`default_nettype wire

/* rtl/core/sbb_out_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// Result queue: up to two pushes and one pop per cycle.
module sbb_out_fifo #(
  parameter int DEPTH = sbb_pkg::FIFO_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire sbb_pkg::push_t             push,
  input  wire sbb_pkg::result_t           d0,
  input  wire sbb_pkg::result_t           d1,
  input  wire logic                       pop,
  output sbb_pkg::result_t                head,
  output logic [$clog2(DEPTH+1)-1:0]      count
);
  localparam int AW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH+1);

  sbb_pkg::result_t mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] wp1;

  assign wp1   = wp_r + AW'(1);
  assign head  = mem[rp_r];
  assign count = cnt_r;

  always_comb begin
    cnt_nxt = cnt_r + NW'(push.push0) + NW'(push.push1) - NW'(pop);
  end

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push.push0) mem[wp_r] <= d0;
    if (push.push1) mem[push.push0 ? wp1 : wp_r] <= d1;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + AW'(push.push0) + AW'(push.push1);
      if (pop) rp_r <= rp_r + AW'(1);
      cnt_r <= cnt_nxt;
    end
  end
endmodule
`default_nettype wire

/* rtl/core/separable_binomial_blur_rgba_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel  | signals                                   | direction
// input    | in_valid in_stall in_cmd in_c0..in_c3     | in, stall out
// result   | out_valid out_stall out_c0..3 out_image_done | out, stall in
// config   | cfg_we cfg_index cfg_data                 | in
// One item per clock while in_stall is low; results pass through the stage-1
// registers and an 8-entry queue. Row memory read is registered and a forwarding register
// covers back-to-back access to the same column (width one).
// Reset clears counters, config and queue; the row memory needs no clearing.
// in_stall rises when the queue holds more than four results.
module separable_binomial_blur_rgba_core #(
  parameter int MAX_WIDTH = sbb_pkg::MAX_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_cmd,
  input  wire logic [7:0]  in_c0,
  input  wire logic [7:0]  in_c1,
  input  wire logic [7:0]  in_c2,
  input  wire logic [7:0]  in_c3,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_c0,
  output logic [7:0]       out_c1,
  output logic [7:0]       out_c2,
  output logic [7:0]       out_c3,
  output logic             out_image_done,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [14:0] cfg_data
);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (WW > 12) ? WW : 12;
  localparam int MW   = 2 * sbb_pkg::PIX_W + sbb_pkg::ERR_W;
  localparam int QW   = $clog2(sbb_pkg::FIFO_DEPTH + 1);

  typedef enum logic [1:0] {M_H1, M_ROW0, M_MID, M_DRAIN} mode_t;

  // configuration
  logic [11:0] width_r;
  logic [14:0] height_r;
  logic        alpha_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 12'd2048;
      height_r <= 15'd1;
      alpha_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sbb_pkg::REG_WIDTH:  width_r  <= cfg_data[11:0];
        sbb_pkg::REG_HEIGHT: height_r <= cfg_data;
        sbb_pkg::REG_ALPHA:  alpha_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective sizes
  logic [CMPW-1:0] wext, wlim;
  logic [WW-1:0]   eff_w;
  logic [14:0]     eff_h;

  assign wext  = CMPW'(width_r);
  assign wlim  = (wext > CMPW'(MAX_WIDTH)) ? CMPW'(MAX_WIDTH) : wext;
  assign eff_w = (width_r == 12'd0) ? WW'(1) : WW'(wlim);
  assign eff_h = (height_r == 15'd0) ? 15'd1 : height_r;

  // stage 0: position and item kind
  logic [CW-1:0] col_r, col_c;
  logic [14:0]   row_r;
  logic          in_acc, go, end_c;
  mode_t         mode_c;
  logic [31:0]   pix_in;
  sbb_pkg::result_t q_head;
  logic [QW-1:0] q_cnt;

  assign in_stall = q_cnt > QW'(sbb_pkg::FIFO_DEPTH - 4);
  assign in_acc   = in_valid && !in_stall;
  assign pix_in   = {in_c3, in_c2, in_c1, in_c0};
  assign col_c    = ({{(WW-CW){1'b0}}, col_r} >= eff_w) ? CW'(eff_w - WW'(1)) : col_r;
  assign end_c    = ({{(WW-CW){1'b0}}, col_c} + WW'(1)) >= eff_w;

  always_comb begin
    if (row_r < eff_h) begin
      go = !in_cmd;
      if (eff_h == 15'd1)    mode_c = M_H1;
      else if (row_r == '0)  mode_c = M_ROW0;
      else                   mode_c = M_MID;
    end else begin
      go     = in_cmd;
      mode_c = M_DRAIN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc && go) begin
      if (end_c) begin
        col_r <= '0;
        if (mode_c == M_H1 || mode_c == M_DRAIN) row_r <= '0;
        else row_r <= row_r + 15'd1;
      end else begin
        col_r <= col_c + CW'(1);
      end
    end
  end

  // stage 1 registers
  logic          s1_v_r, s1_w1_r, s1_col0_r, s1_end_r;
  mode_t         s1_mode_r;
  logic [CW-1:0] s1_col_r;
  logic [31:0]   s1_p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_acc && go;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mode_r <= mode_c;
      s1_col_r  <= col_c;
      s1_p_r    <= pix_in;
      s1_w1_r   <= eff_w == WW'(1);
      s1_col0_r <= col_c == '0;
      s1_end_r  <= end_c;
    end
  end

  // row memory {error, newer row, older row} with forwarding
  logic [MW-1:0] mem [MAX_WIDTH];
  logic [MW-1:0] q_r, fwd_d_r, rd, wd;
  logic          fwd_r, we;

  always_ff @(posedge clk) begin
    if (we) mem[s1_col_r] <= wd;
    if (in_acc) begin
      q_r     <= mem[col_c];
      fwd_r   <= we && (s1_col_r == col_c);
      fwd_d_r <= wd;
    end
  end

  assign rd = fwd_r ? fwd_d_r : q_r;

  // vertical pass
  logic [31:0] va, vb, vc, v_pix, hv;
  logic [7:0]  ve, v_err;

  assign va = rd[31:0];
  assign vb = rd[63:32];
  assign ve = rd[MW-1:64];
  assign vc = (s1_mode_r == M_DRAIN) ? vb : s1_p_r;

  sbb_pass u_vpass (
    .a(va), .b(vb), .c(vc), .err_in(ve), .alpha_en(alpha_r),
    .pix(v_pix), .err_out(v_err)
  );

  assign hv = (s1_mode_r == M_H1) ? s1_p_r : v_pix;

  always_comb begin
    we = s1_v_r && (s1_mode_r != M_H1);
    case (s1_mode_r)
      M_ROW0:  wd = {sbb_pkg::ERR_RST, s1_p_r, s1_p_r};
      M_MID:   wd = {v_err, s1_p_r, vb};
      default: wd = {v_err, vb, va};
    endcase
  end

  // horizontal pass
  logic [63:0] win_r;
  logic [7:0]  rerr_r, e1, e2;
  logic [31:0] o1, o2;
  logic        last_row, h_act;

  sbb_pass u_hpass0 (
    .a(win_r[31:0]), .b(win_r[63:32]), .c(hv), .err_in(rerr_r),
    .alpha_en(alpha_r), .pix(o1), .err_out(e1)
  );

  sbb_pass u_hpass1 (
    .a(win_r[63:32]), .b(hv), .c(hv), .err_in(e1),
    .alpha_en(alpha_r), .pix(o2), .err_out(e2)
  );

  assign last_row = s1_mode_r != M_MID;
  assign h_act    = s1_v_r && (s1_mode_r != M_ROW0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= '0;
      rerr_r <= sbb_pkg::ERR_RST;
    end else if (h_act && !s1_w1_r) begin
      if (s1_col0_r) begin
        win_r  <= {hv, hv};
        rerr_r <= sbb_pkg::ERR_RST;
      end else begin
        win_r  <= {hv, win_r[63:32]};
        rerr_r <= s1_end_r ? e2 : e1;
      end
    end
  end

  // queue pushes
  sbb_pkg::push_t   push;
  sbb_pkg::result_t d0, d1;

  always_comb begin
    push.push0 = h_act && (s1_w1_r || !s1_col0_r);
    push.push1 = h_act && !s1_w1_r && !s1_col0_r && s1_end_r;
    if (s1_w1_r) begin
      d0.pix  = hv;
      d0.done = last_row;
    end else begin
      d0.pix  = o1;
      d0.done = 1'b0;
    end
    d1.pix  = o2;
    d1.done = last_row;
  end

  sbb_out_fifo #(.DEPTH(sbb_pkg::FIFO_DEPTH)) u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .d0(d0), .d1(d1),
    .pop(out_valid && !out_stall), .head(q_head), .count(q_cnt)
  );

  assign out_valid      = q_cnt != '0;
  assign out_c0         = q_head.pix[7:0];
  assign out_c1         = q_head.pix[15:8];
  assign out_c2         = q_head.pix[23:16];
  assign out_c3         = q_head.pix[31:24];
  assign out_image_done = q_head.done;
endmodule
`default_nettype wire
